// ===== hw/rtl/y2a_pkg.sv =====
// shared types and constants for the yuy2 to argb pair unpacker
`default_nettype none
package y2a_pkg;

	// configuration register indexes
	typedef enum logic [0:0] {
		RegKeyEnable    = 1'b0,
		RegKeyThreshold = 1'b1
	} cfg_reg_t;

	// widths of the conversion datapath
	localparam int ProdW   = 18;
	localparam int SumW    = 19;
	localparam int ThreshW = 9;

	// bt.601 studio-range coefficients and offsets
	localparam logic signed [ProdW-1:0] CoefY     = 18'sd298;
	localparam logic signed [ProdW-1:0] CoefRv    = 18'sd409;
	localparam logic signed [ProdW-1:0] CoefGu    = 18'sd100;
	localparam logic signed [ProdW-1:0] CoefGv    = 18'sd208;
	localparam logic signed [ProdW-1:0] CoefBu    = 18'sd516;
	localparam logic signed [ProdW-1:0] LumaOff   = 18'sd16;
	localparam logic signed [ProdW-1:0] ChromaOff = 18'sd128;
	localparam logic signed [SumW-1:0]  RoundAdd  = 19'sd128;
	localparam logic signed [SumW-1:0]  ByteMax   = 19'sd255;
	localparam logic [7:0]              AlphaOn   = 8'hff;

	// chroma contributions shared by both lanes
	typedef struct packed {
		logic signed [ProdW-1:0] r_term;
		logic signed [ProdW-1:0] g_term;
		logic signed [ProdW-1:0] b_term;
	} chroma_t;

endpackage
`default_nettype wire

// ===== hw/rtl/y2a_chroma.sv =====
// shared chroma products for both pixel lanes
`default_nettype none
module y2a_chroma (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [7:0]       u,
	input  wire logic [7:0]       v,
	output y2a_pkg::chroma_t      chroma_s1
);
	import y2a_pkg::*;

	logic signed [ProdW-1:0] d_val;
	logic signed [ProdW-1:0] e_val;
	chroma_t                 chroma_d;

	// centre chroma and scale by the fixed coefficients
	always_comb begin
		d_val = $signed({{(ProdW-8){1'b0}}, u}) - ChromaOff;
		e_val = $signed({{(ProdW-8){1'b0}}, v}) - ChromaOff;
		chroma_d.r_term = ProdW'(e_val * CoefRv);
		chroma_d.g_term = ProdW'(-(d_val * CoefGu) - (e_val * CoefGv));
		chroma_d.b_term = ProdW'(d_val * CoefBu);
	end

	// stage one register
	always_ff @(posedge clk) begin
		if (en) begin
			chroma_s1 <= chroma_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/y2a_lane.sv =====
// one pixel lane: luma product, channel sums, floor shift and clamp
`default_nettype none
module y2a_lane (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [7:0]       y,
	input  y2a_pkg::chroma_t      chroma_s1,
	output logic [23:0]           rgb
);
	import y2a_pkg::*;

	logic signed [ProdW-1:0] luma_c;
	logic signed [ProdW-1:0] luma_s1;
	logic signed [SumW-1:0]  sum_r;
	logic signed [SumW-1:0]  sum_g;
	logic signed [SumW-1:0]  sum_b;

	function automatic logic [7:0] clamp_byte(input logic signed [SumW-1:0] s);
		logic signed [SumW-1:0] sh;
		sh = s >>> 8;
		if (sh < 0) begin
			clamp_byte = 8'h00;
		end else if (sh > ByteMax) begin
			clamp_byte = 8'hff;
		end else begin
			clamp_byte = sh[7:0];
		end
	endfunction

	// scaled luma, registered alongside the chroma products
	assign luma_c = $signed({{(ProdW-8){1'b0}}, y}) - LumaOff;

	always_ff @(posedge clk) begin
		if (en) begin
			luma_s1 <= ProdW'(luma_c * CoefY);
		end
	end

	// channel sums with rounding
	always_comb begin
		sum_r = SumW'(luma_s1) + SumW'(chroma_s1.r_term) + RoundAdd;
		sum_g = SumW'(luma_s1) + SumW'(chroma_s1.g_term) + RoundAdd;
		sum_b = SumW'(luma_s1) + SumW'(chroma_s1.b_term) + RoundAdd;
	end

	// shift down and clamp each channel
	assign rgb = {clamp_byte(sum_r), clamp_byte(sum_g), clamp_byte(sum_b)};

endmodule
`default_nettype wire

// ===== hw/rtl/yuy2_to_argb_pair_unpack_top.sv =====
// yuy2 to argb pair unpacker: two pixel lanes and the alpha and keying merge
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+-------------------------------
//  input    | in_valid, in_stall, yuy2_word    | one packed yuy2 word
//  output   | out_valid, out_stall, *_argb     | two argb pixels per word
//  config   | cfg_we, cfg_index, cfg_data      | keying enable and threshold
//
// one word per cycle sustained while the output is not stalled; an accepted word is registered
// in stage one (product stage), then in the output register (sum, clamp and merge stage).
// reset clears the configuration registers and the stage valid flags.
// a stalled output holds its word; a new word is still taken while stage one
// is empty, and in_stall rises only when stage one is full and blocked.
`default_nettype none
module yuy2_to_argb_pair_unpack_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  y2a_pkg::cfg_reg_t          cfg_index,
	input  wire logic [8:0]            cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [31:0]           yuy2_word,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [31:0]                first_pixel_argb,
	output logic [31:0]                second_pixel_argb
);
	import y2a_pkg::*;

	logic               keying_enable_q;
	logic [ThreshW-1:0] key_threshold_q;
	logic               valid_s1;
	logic               valid_s2;
	logic               key_s1;
	logic               en_s1;
	logic               en_s2;
	logic               key_d;
	logic               all_below;
	chroma_t            chroma_s1;
	logic [23:0]        rgb_first;
	logic [23:0]        rgb_second;
	logic [7:0]         alpha;
	logic [31:0]        first_s2;
	logic [31:0]        second_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keying_enable_q <= 1'b0;
			key_threshold_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegKeyEnable:    keying_enable_q <= cfg_data[0];
				RegKeyThreshold: key_threshold_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// pipeline advance
	assign en_s2    = !valid_s2 || !out_stall;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// background key decision on the incoming word
	assign all_below = ({1'b0, yuy2_word[31:24]} < key_threshold_q) &&
	                   ({1'b0, yuy2_word[23:16]} < key_threshold_q) &&
	                   ({1'b0, yuy2_word[15:8]}  < key_threshold_q) &&
	                   ({1'b0, yuy2_word[7:0]}   < key_threshold_q);
	assign key_d = keying_enable_q && ((yuy2_word == '0) || all_below);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			key_s1 <= key_d;
		end
	end

	// shared chroma and the two pixel lanes
	y2a_chroma u_chroma (
		.clk       (clk),
		.en        (en_s1),
		.u         (yuy2_word[23:16]),
		.v         (yuy2_word[7:0]),
		.chroma_s1 (chroma_s1)
	);

	y2a_lane u_lane_first (
		.clk       (clk),
		.en        (en_s1),
		.y         (yuy2_word[31:24]),
		.chroma_s1 (chroma_s1),
		.rgb       (rgb_first)
	);

	y2a_lane u_lane_second (
		.clk       (clk),
		.en        (en_s1),
		.y         (yuy2_word[15:8]),
		.chroma_s1 (chroma_s1),
		.rgb       (rgb_second)
	);

	// merge: shared alpha and keying
	assign alpha = ((rgb_first != '0) || (rgb_second != '0)) ? AlphaOn : 8'h00;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			if (key_s1) begin
				first_s2  <= '0;
				second_s2 <= '0;
			end else begin
				first_s2  <= {alpha, rgb_first};
				second_s2 <= {alpha, rgb_second};
			end
		end
	end

	assign out_valid         = valid_s2;
	assign first_pixel_argb  = first_s2;
	assign second_pixel_argb = second_s2;

`ifndef SYNTHESIS
	// stall only when stage one holds a word
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with stage one empty");

	// an accepted word lands in stage one
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted word lost before stage one");

	// stage one moves to the output when it advances
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && en_s2 |=> out_valid)
		else $error("stage one word did not reach the output");

	// both pixels share one alpha
	a_alpha_shared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> first_pixel_argb[31:24] == second_pixel_argb[31:24])
		else $error("pixel alphas differ");

	// zero alpha only for an all-zero pair
	a_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (first_pixel_argb[31:24] == 8'h00) |->
			(first_pixel_argb == '0) && (second_pixel_argb == '0))
		else $error("zero alpha with colour present");
`endif

endmodule
`default_nettype wire

// ===== tb/argb_pair_checker.sv =====
// checker for the yuy2 to argb pair unpacker: predicts each pixel pair and compares
`timescale 1ns / 100ps
module argb_pair_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  y2a_pkg::cfg_reg_t cfg_index,
	input  wire logic [8:0]   cfg_data,
	input  wire logic         in_valid,
	input  wire logic         in_stall,
	input  wire logic [31:0]  yuy2_word,
	input  wire logic         out_valid,
	input  wire logic         out_stall,
	input  wire logic [31:0]  first_pixel_argb,
	input  wire logic [31:0]  second_pixel_argb,
	input  wire logic         at_end,
	output int                words_pending,
	output int                mismatches
);
	import y2a_pkg::*;

	typedef struct packed {
		logic [31:0] first;
		logic [31:0] second;
	} argb_pair_t;

	argb_pair_t pair_q[$];
	logic       key_en;
	logic [8:0] key_thr;
	int         errs = 0;
	bit         end_seen = 1'b0;

	// one line per failure, quiet once the log is full enough
	task automatic report(input string what);
		errs++;
		if (errs <= 40)
			$display("%0t ns  mismatch: %s", $time, what);
	endtask

	function automatic logic [7:0] sat_byte(input int v);
		if (v < 0)
			return 8'h00;
		if (v > 255)
			return 8'hff;
		return v[7:0];
	endfunction

	// bt.601 studio range, floor of the scaled sum, then clamped per channel
	function automatic logic [23:0] lane_rgb(input logic [7:0] luma, input logic [7:0] cb,
			input logic [7:0] cr);
		int c;
		int d;
		int e;
		c = int'(luma) - 16;
		d = int'(cb) - 128;
		e = int'(cr) - 128;
		return {sat_byte((298 * c + 409 * e + 128) >>> 8),
			sat_byte((298 * c - 100 * d - 208 * e + 128) >>> 8),
			sat_byte((298 * c + 516 * d + 128) >>> 8)};
	endfunction

	function automatic argb_pair_t predict_pair(input logic [31:0] w);
		argb_pair_t p;
		logic [23:0] rgb1;
		logic [23:0] rgb2;
		logic [7:0]  alpha;
		// background keying blanks the whole pair
		if (key_en && (w == 32'h0 || ({1'b0, w[31:24]} < key_thr && {1'b0, w[23:16]} < key_thr &&
				{1'b0, w[15:8]} < key_thr && {1'b0, w[7:0]} < key_thr))) begin
			p.first  = 32'h0;
			p.second = 32'h0;
			return p;
		end
		rgb1  = lane_rgb(w[31:24], w[23:16], w[7:0]);
		rgb2  = lane_rgb(w[15:8], w[23:16], w[7:0]);
		alpha = (rgb1 == 24'h0 && rgb2 == 24'h0) ? 8'h00 : 8'hff;
		p.first  = {alpha, rgb1};
		p.second = {alpha, rgb2};
		return p;
	endfunction

	// shadow copy of the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_en  <= 1'b0;
			key_thr <= 9'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegKeyEnable:    key_en  <= cfg_data[0];
				RegKeyThreshold: key_thr <= cfg_data;
				default: ;
			endcase
		end
	end

	// queue predictions on accepted input words, compare accepted output words
	always @(posedge clk) begin
		argb_pair_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pair_q.push_back(predict_pair(yuy2_word));
			if (out_valid && !out_stall) begin
				if (pair_q.size() == 0) begin
					report($sformatf("output word %h %h with nothing expected",
						first_pixel_argb, second_pixel_argb));
				end else begin
					want = pair_q.pop_front();
					if (first_pixel_argb !== want.first)
						report($sformatf("first_pixel_argb %h, expected %h",
							first_pixel_argb, want.first));
					if (second_pixel_argb !== want.second)
						report($sformatf("second_pixel_argb %h, expected %h",
							second_pixel_argb, want.second));
				end
			end
			if (at_end && !end_seen) begin
				end_seen = 1'b1;
				if (pair_q.size() != 0)
					report($sformatf("%0d expected words never came out", pair_q.size()));
			end
		end
		words_pending <= pair_q.size();
		mismatches    <= errs;
	end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the yuy2 to argb pair unpacker
`timescale 1ns / 100ps
module testbench;
	import y2a_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int Settle     = 6;

	typedef struct packed {
		logic        key_en;
		logic [8:0]  thr;
		logic [31:0] word;
	} directed_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	cfg_reg_t    cfg_index = RegKeyEnable;
	logic [8:0]  cfg_data = 9'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] yuy2_word = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] first_pixel_argb;
	logic [31:0] second_pixel_argb;
	logic        at_end = 1'b0;
	int          words_pending;
	int          mismatches;

	bit          calm_tx = 1'b1;
	bit          calm_rx = 1'b1;
	int          stall_left = 0;
	logic        cur_en = 1'b0;
	logic [8:0]  cur_thr = 9'd0;

	directed_word_t directed_q[$];

	yuy2_to_argb_pair_unpack_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.yuy2_word         (yuy2_word),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.first_pixel_argb  (first_pixel_argb),
		.second_pixel_argb (second_pixel_argb)
	);

	argb_pair_checker pair_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.yuy2_word         (yuy2_word),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.first_pixel_argb  (first_pixel_argb),
		.second_pixel_argb (second_pixel_argb),
		.at_end            (at_end),
		.words_pending     (words_pending),
		.mismatches        (mismatches)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (!calm_rx)
				stall_left <= idle_len();
		end
	end

	// random word, biased towards keying edges, extremes and near-black pairs
	function automatic logic [31:0] pick_word(input logic [8:0] thr);
		logic [7:0] b [4];
		int         top_below;
		top_below = (thr > 9'd256) ? 255 : int'(thr) - 1;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4: begin
				for (int k = 0; k < 4; k++) begin
					case ($urandom_range(0, 3))
						0: b[k] = 8'h00;
						1: b[k] = 8'h01;
						2: b[k] = 8'hfe;
						default: b[k] = 8'hff;
					endcase
				end
			end
			5, 6: begin
				for (int k = 0; k < 4; k++) begin
					if (top_below >= 0 && $urandom_range(0, 5) != 0)
						b[k] = 8'($urandom_range(0, top_below > 255 ? 255 : top_below));
					else
						b[k] = thr[7:0] + 8'($urandom_range(0, 2));
				end
			end
			7: begin
				b[0] = 8'($urandom_range(16, 235));
				b[1] = 8'($urandom_range(16, 240));
				b[2] = 8'($urandom_range(16, 235));
				b[3] = 8'($urandom_range(16, 240));
			end
			8: begin
				b[0] = 8'($urandom_range(0, 20));
				b[1] = 8'($urandom_range(120, 136));
				b[2] = 8'($urandom_range(0, 20));
				b[3] = 8'($urandom_range(120, 136));
			end
			default: begin
				if ($urandom_range(0, 1) == 0)
					return 32'h0;
				return 32'h1 << $urandom_range(0, 31);
			end
		endcase
		return {b[0], b[1], b[2], b[3]};
	endfunction

	// one word onto the input channel, held until taken
	task automatic send_word(input logic [31:0] w);
		int gap;
		gap = calm_tx ? 0 : idle_len();
		if (gap != 0) begin
			in_valid  <= 1'b0;
			yuy2_word <= $urandom();
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		yuy2_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// hold off until every expected word has come out, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	// both registers rewritten with the block idle
	task automatic apply_cfg(input logic en, input logic [8:0] thr);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= RegKeyEnable;
		cfg_data  <= {8'd0, en};
		@(posedge clk);
		cfg_index <= RegKeyThreshold;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_en  = en;
		cur_thr = thr;
	endtask

	// run out of time
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("yuy2_to_argb_pair_unpack_top regression: fail");
		$finish;
	end

	initial begin
		logic       en;
		logic [8:0] thr;

		// extremes and keying corners
		directed_q.push_back({1'b0, 9'd0, 32'h00000000});
		directed_q.push_back({1'b0, 9'd0, 32'hffffffff});
		directed_q.push_back({1'b0, 9'd0, 32'h10801080});
		directed_q.push_back({1'b0, 9'd0, 32'heb80eb80});
		directed_q.push_back({1'b0, 9'd0, 32'h00ff00ff});
		directed_q.push_back({1'b0, 9'd0, 32'hff00ff00});
		directed_q.push_back({1'b0, 9'd0, 32'h10ff1000});
		directed_q.push_back({1'b0, 9'd0, 32'haa55aa55});
		directed_q.push_back({1'b0, 9'd0, 32'h55aa55aa});
		directed_q.push_back({1'b0, 9'd0, 32'h80808080});
		directed_q.push_back({1'b0, 9'd0, 32'hebf010f0});
		directed_q.push_back({1'b1, 9'd1, 32'h00000000});
		directed_q.push_back({1'b1, 9'd1, 32'h00000001});
		directed_q.push_back({1'b1, 9'd1, 32'h01010101});
		directed_q.push_back({1'b1, 9'd256, 32'hffffffff});
		directed_q.push_back({1'b1, 9'd256, 32'h12345678});
		directed_q.push_back({1'b1, 9'd64, 32'h3f3f3f3f});
		directed_q.push_back({1'b1, 9'd64, 32'h3f3f3f40});
		directed_q.push_back({1'b1, 9'd64, 32'h403f3f3f});
		directed_q.push_back({1'b1, 9'd64, 32'h00000000});
		directed_q.push_back({1'b1, 9'd0, 32'h00000000});
		directed_q.push_back({1'b1, 9'd0, 32'h00000100});
		directed_q.push_back({1'b1, 9'd255, 32'hfefefefe});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words, configuration changed only between runs of words
		apply_cfg(1'b0, 9'd0);
		foreach (directed_q[i]) begin
			if (directed_q[i].key_en != cur_en || directed_q[i].thr != cur_thr)
				apply_cfg(directed_q[i].key_en, directed_q[i].thr);
			send_word(directed_q[i].word);
		end

		// random phases over several settings, extremes first
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin en = 1'b0; thr = 9'd0;   end
				1: begin en = 1'b1; thr = 9'd0;   end
				2: begin en = 1'b1; thr = 9'd256; end
				3: begin en = 1'b1; thr = 9'd1;   end
				4: begin en = 1'b1; thr = 9'd255; end
				5: begin en = 1'b0; thr = 9'd256; end
				6: begin en = 1'b1; thr = 9'd16;  end
				default: begin
					en  = ($urandom_range(0, 3) != 0);
					thr = 9'($urandom_range(0, 256));
				end
			endcase
			apply_cfg(en, thr);
			calm_tx = (ph % 4 == 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
			calm_rx = (ph % 4 == 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 180; i++) begin
				// sender holds back mid-phase until the pipe has drained
				if (ph == 3 && i == 90)
					wait_idle();
				send_word(pick_word(thr));
			end
		end

		// drain, then flag anything still owed
		wait_idle();
		at_end <= 1'b1;
		repeat (2) @(posedge clk);
		if (mismatches == 0)
			$display("yuy2_to_argb_pair_unpack_top regression: pass");
		else
			$display("yuy2_to_argb_pair_unpack_top regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/y2a_pkg.sv
hw/rtl/y2a_chroma.sv
hw/rtl/y2a_lane.sv
hw/rtl/yuy2_to_argb_pair_unpack_top.sv
tb/argb_pair_checker.sv
tb/testbench.sv
